// ===== rtl/core/pot_angle_wrap_average_assert.svh =====
`ifndef POT_ANGLE_WRAP_AVERAGE_ASSERT_SVH
`define POT_ANGLE_WRAP_AVERAGE_ASSERT_SVH

// clocked property, off while reset is active
`define PAW_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition that must never hold
`define PAW_ASSERT_NEVER(name, cond, msg) \
  `PAW_ASSERT(name, !(cond), msg)

`endif

// ===== rtl/core/paw_pkg.sv =====
`default_nettype none

package paw_pkg;

  localparam int unsigned DataW   = 20;
  localparam int unsigned JumpW   = 19;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegMin    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMax    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegOffset = 2'd2;
  localparam logic [CfgIdxW-1:0] RegJump   = 2'd3;

  localparam logic [DataW-1:0] MinReset    = 20'd0;
  localparam logic [DataW-1:0] MaxReset    = 20'd5760;
  localparam logic [DataW-1:0] OffsetReset = 20'd0;
  localparam logic [JumpW-1:0] JumpReset   = 19'd4800;

  localparam logic [DataW-1:0] QMax = 20'h7FFFF;
  localparam logic [DataW-1:0] QMin = 20'h80000;

  typedef struct packed {
    logic [DataW-1:0] min_value;
    logic [DataW-1:0] max_value;
    logic [DataW-1:0] offset;
    logic [JumpW-1:0] jump_limit;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] value;
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/core/pot_angle_wrap_average.sv =====
// channel  | valid        | ready        | payload
// config   | cfg_we_i     | (none)       | cfg_idx_i, cfg_data_i
// input    | in_valid_i   | in_ready_o   | reading_i
// output   | out_valid_o  | out_ready_i  | angle_o, averaged_o
//
// one request per clock while in_ready_o is high; a full queue holds the front
// front: jump check, offset add, wrap and saturate in two register stages
// back: running window sum, reciprocal multiply and correction in three stages
// a two-entry queue between the halves lets either side stall on its own
// reset loads config defaults and clears previous raw value, window, fill count and all valids
`default_nettype none

module pot_angle_wrap_average #(
  parameter int unsigned WINDOW = 4
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [paw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [paw_pkg::DataW-1:0]    cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [paw_pkg::DataW-1:0]    reading_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [paw_pkg::DataW-1:0]         angle_o,
  output logic                              averaged_o
);

  paw_pkg::cfg_t  cfg_q, cfg_d;
  paw_pkg::item_t push, pop;
  logic           push_ready, take;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        paw_pkg::RegMin:    cfg_d.min_value  = cfg_data_i;
        paw_pkg::RegMax:    cfg_d.max_value  = cfg_data_i;
        paw_pkg::RegOffset: cfg_d.offset     = cfg_data_i;
        paw_pkg::RegJump:   cfg_d.jump_limit = cfg_data_i[paw_pkg::JumpW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_value  <= paw_pkg::MinReset;
      cfg_q.max_value  <= paw_pkg::MaxReset;
      cfg_q.offset     <= paw_pkg::OffsetReset;
      cfg_q.jump_limit <= paw_pkg::JumpReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  paw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .reading_i    (reading_i),
    .push_o       (push),
    .push_ready_i (push_ready)
  );

  paw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .pop_o        (pop),
    .pop_i        (take)
  );

  paw_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_i       (pop),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .angle_o     (angle_o),
    .averaged_o  (averaged_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/paw_front.sv =====
`default_nettype none

module paw_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire paw_pkg::cfg_t              cfg_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [paw_pkg::DataW-1:0]  reading_i,
  output paw_pkg::item_t                  push_o,
  input  wire logic                       push_ready_i
);

  localparam int unsigned ExtW = paw_pkg::DataW + 3;

  logic                      en;
  logic                      a_valid_q, a_valid_d;
  logic                      b_valid_q, b_valid_d;
  logic [paw_pkg::DataW-1:0] last_raw_q, last_raw_d;
  logic [paw_pkg::DataW-1:0] a_raw_q, a_raw_d;
  logic signed [ExtW-1:0]    b_v_q, b_v_d;

  logic signed [ExtW-1:0]    diff, jump_ext;
  logic                      too_big;
  logic [paw_pkg::DataW-1:0] raw_sel;

  logic signed [ExtW-1:0]    min_ext, max_ext, range, w_sub, w_add, wrapped;
  logic                      c_hi, c_lo;
  logic [paw_pkg::DataW-1:0] sat_value;

  assign en         = !b_valid_q || push_ready_i;
  assign in_ready_o = en;

  // jump check against the previous raw value
  always_comb begin
    diff     = ExtW'($signed(reading_i)) - ExtW'($signed(last_raw_q));
    jump_ext = $signed(ExtW'(cfg_i.jump_limit));
    too_big  = diff > jump_ext;
    raw_sel  = too_big ? last_raw_q : reading_i;
  end

  always_comb begin
    a_valid_d  = a_valid_q;
    b_valid_d  = b_valid_q;
    last_raw_d = last_raw_q;
    a_raw_d    = a_raw_q;
    b_v_d      = b_v_q;
    if (en) begin
      a_valid_d = in_valid_i;
      b_valid_d = a_valid_q;
      a_raw_d   = raw_sel;
      b_v_d     = ExtW'($signed(a_raw_q)) + ExtW'($signed(cfg_i.offset));
      if (in_valid_i) begin
        last_raw_d = raw_sel;
      end
    end
  end

  // wrap into [min, max] with both conditional steps evaluated side by side, then saturate
  always_comb begin
    min_ext = ExtW'($signed(cfg_i.min_value));
    max_ext = ExtW'($signed(cfg_i.max_value));
    range   = max_ext - min_ext;
    w_sub   = b_v_q - range;
    w_add   = b_v_q + range;
    c_hi    = b_v_q > max_ext;
    c_lo    = c_hi ? (w_sub < min_ext) : (b_v_q < min_ext);
    if (c_hi) begin
      wrapped = c_lo ? b_v_q : w_sub;
    end else begin
      wrapped = c_lo ? w_add : b_v_q;
    end
    if (wrapped > ExtW'($signed(paw_pkg::QMax))) begin
      sat_value = paw_pkg::QMax;
    end else if (wrapped < ExtW'($signed(paw_pkg::QMin))) begin
      sat_value = paw_pkg::QMin;
    end else begin
      sat_value = wrapped[paw_pkg::DataW-1:0];
    end
  end

  assign push_o.valid = b_valid_q;
  assign push_o.value = sat_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q  <= 1'b0;
      b_valid_q  <= 1'b0;
      last_raw_q <= '0;
    end else begin
      a_valid_q  <= a_valid_d;
      b_valid_q  <= b_valid_d;
      last_raw_q <= last_raw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_raw_q <= a_raw_d;
    b_v_q   <= b_v_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/paw_queue.sv =====
`default_nettype none

module paw_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire paw_pkg::item_t push_i,
  output logic                push_ready_o,
  output paw_pkg::item_t      pop_o,
  input  wire logic           pop_i
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [paw_pkg::DataW-1:0] mem_q [Depth];
  logic [PtrW-1:0]           wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]           rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]           count_q, count_d;
  logic                      do_push, do_pop;

  assign push_ready_o = count_q != CntW'(Depth);
  assign pop_o.valid  = count_q != '0;
  assign pop_o.value  = mem_q[rd_ptr_q];

  assign do_push = push_i.valid && push_ready_o;
  assign do_pop  = pop_i && pop_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.value;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/paw_back.sv =====
`default_nettype none

module paw_back #(
  parameter int unsigned WINDOW = 4
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire paw_pkg::item_t            pop_i,
  output logic                           take_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [paw_pkg::DataW-1:0]      angle_o,
  output logic                           averaged_o
);

  `include "pot_angle_wrap_average_assert.svh"

  localparam int unsigned DataW = paw_pkg::DataW;
  localparam int unsigned CntW  = $clog2(WINDOW + 1);
  localparam int unsigned SumW  = $clog2(WINDOW) + DataW;
  localparam logic [SumW-1:0] Bias  = SumW'(WINDOW * (1 << (DataW - 1)));
  localparam logic [SumW-1:0] Recip = SumW'((64'd1 << SumW) / WINDOW);
  localparam logic [SumW-1:0] WinC  = SumW'(WINDOW);

  logic                    en;
  logic [DataW-1:0]        win_q [WINDOW];
  logic [DataW-1:0]        win_d [WINDOW];
  logic signed [SumW-1:0]  sum_q, sum_d;
  logic [CntW-1:0]         fill_q, fill_d;
  logic signed [SumW-1:0]  new_sum;
  logic                    avg_now;

  logic                    s1_valid_q, s1_avg_q;
  logic [DataW-1:0]        s1_direct_q;
  logic [SumW-1:0]         s1_sumu_q;

  logic [2*SumW-1:0]       prod;
  logic                    s2_valid_q, s2_avg_q;
  logic [DataW-1:0]        s2_direct_q, s2_qest_q;
  logic [SumW-1:0]         s2_sumu_q;

  logic [SumW-1:0]         qw, rem;
  logic [DataW-1:0]        quo, mean;

  logic                    out_valid_q, avg_q;
  logic [DataW-1:0]        angle_q;

  assign en     = !out_valid_q || out_ready_i;
  assign take_o = en && pop_i.valid;

  // window shift and running sum
  always_comb begin
    for (int i = 0; i < int'(WINDOW) - 1; i++) begin
      win_d[i] = win_q[i+1];
    end
    win_d[WINDOW-1] = pop_i.value;
    new_sum = sum_q + SumW'($signed(pop_i.value)) - SumW'($signed(win_q[0]));
    avg_now = fill_q >= CntW'(WINDOW - 1);
    sum_d   = take_o ? new_sum : sum_q;
    fill_d  = fill_q;
    if (take_o && fill_q != CntW'(WINDOW)) begin
      fill_d = fill_q + 1'b1;
    end
  end

  // floor division by the window length through a biased reciprocal product
  assign prod = s1_sumu_q * Recip;

  always_comb begin
    qw   = SumW'(s2_qest_q) * WinC;
    rem  = s2_sumu_q - qw;
    quo  = s2_qest_q + DataW'(rem >= WinC);
    mean = {~quo[DataW-1], quo[DataW-2:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(WINDOW); i++) begin
        win_q[i] <= '0;
      end
      sum_q       <= '0;
      fill_q      <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_o) begin
        for (int i = 0; i < int'(WINDOW); i++) begin
          win_q[i] <= win_d[i];
        end
      end
      sum_q  <= sum_d;
      fill_q <= fill_d;
      if (en) begin
        s1_valid_q  <= pop_i.valid;
        s2_valid_q  <= s1_valid_q;
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_avg_q    <= avg_now;
      s1_direct_q <= pop_i.value;
      s1_sumu_q   <= SumW'(new_sum) + Bias;
      s2_avg_q    <= s1_avg_q;
      s2_direct_q <= s1_direct_q;
      s2_sumu_q   <= s1_sumu_q;
      s2_qest_q   <= prod[SumW +: DataW];
      avg_q       <= s2_avg_q;
      angle_q     <= s2_avg_q ? mean : s2_direct_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign angle_o     = angle_q;
  assign averaged_o  = avg_q;

  `PAW_ASSERT_NEVER(a_fill_range, fill_q > CntW'(WINDOW), "fill count beyond window")
  `PAW_ASSERT(a_avg_full, (s1_valid_q && s1_avg_q) |-> (fill_q == CntW'(WINDOW)), "early mean")
  `PAW_ASSERT(a_rem_bound, s2_valid_q |-> (rem < (WinC << 1)), "quotient estimate off")

endmodule

`default_nettype wire
